/* design/pidc_pkg.sv */
// Shared types, constants and fixed-point helpers of the PID controller.
package pidc_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned GainW  = 31;
    localparam int unsigned DtW    = 16;
    localparam int unsigned MulW   = 33;
    localparam int unsigned ProdW  = 2 * MulW;
    localparam int unsigned DvdW   = 48;
    localparam int unsigned OptW   = 7;
    localparam int unsigned IdxW   = 3;

    // Width of the taper region above full_rate_band, Q16.16.
    localparam logic [MulW-1:0] TaperBand = 33'd65536;

    // Register indexes on the configuration port.
    typedef enum logic [IdxW-1:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_DERIV_GAIN  = 3'd2,
        REG_OUTPUT_MAX  = 3'd3,
        REG_INTEG_LIMIT = 3'd4,
        REG_DEAD_BAND   = 3'd5,
        REG_OPTION_BITS = 3'd6,
        REG_FULL_RATE   = 3'd7
    } reg_index_t;

    // Bits of option_bits.
    localparam int unsigned OptTrap    = 0;
    localparam int unsigned OptVarRate = 1;
    localparam int unsigned OptDMeas   = 2;
    localparam int unsigned OptILimit  = 4;
    localparam int unsigned OptPass    = 6;

    // Saturate a signed 34-bit value to the signed 32-bit range.
    function automatic logic signed [DataW-1:0] sat34(input logic signed [DataW+1:0] v);
        logic signed [DataW+1:0] hi;
        logic signed [DataW+1:0] lo;
        hi = 34'sh0_7FFF_FFFF;
        lo = -34'sh0_8000_0000;
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[DataW-1:0];
    endfunction

    // Product shifted right by 16 with floor rounding, saturated to 32 bits.
    function automatic logic signed [DataW-1:0] qsat(input logic signed [ProdW-1:0] prod);
        logic signed [ProdW-17:0] sh;
        logic signed [ProdW-17:0] hi;
        logic signed [ProdW-17:0] lo;
        sh = prod[ProdW-1:16];
        hi = 50'sh0_7FFF_FFFF;
        lo = -50'sh0_8000_0000;
        if (sh > hi)
            return 32'sh7FFF_FFFF;
        else if (sh < lo)
            return 32'sh8000_0000;
        else
            return sh[DataW-1:0];
    endfunction

endpackage

/* design/pidc_mul.sv */
// Registered signed 33x33 multiplier shared by every product of the controller.
module pidc_mul (
    input  logic                                clk,
    input  logic signed [pidc_pkg::MulW-1:0]    op_a,
    input  logic signed [pidc_pkg::MulW-1:0]    op_b,
    output logic signed [pidc_pkg::ProdW-1:0]   prod
);
    import pidc_pkg::*;

    logic signed [ProdW-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

/* design/pidc_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned 48 by 31 bits.
module pidc_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pidc_pkg::DvdW-1:0]       dividend,
    input  logic [pidc_pkg::GainW-1:0]      divisor,
    output logic                            done,
    output logic [pidc_pkg::DvdW-1:0]       quotient
);
    import pidc_pkg::*;

    logic [DvdW-1:0]  quo_reg, quo_next;
    logic [GainW:0]   rem_reg, rem_next;
    logic [GainW-1:0] dsr_reg, dsr_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [GainW+1:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DvdW-1]} - {2'b00, dsr_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = 6'(DvdW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit and subtract when it fits
            if (!trial[GainW+1])
            begin
                rem_next = trial[GainW:0];
                quo_next = {quo_reg[DvdW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[GainW-1:0], quo_reg[DvdW-1]};
                quo_next = {quo_reg[DvdW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* design/pid_controller_with_options_top.sv */
// PID controller top level: stream ports, registers, sequencer and state.
// Each request passes S_CHK, S_M1 to S_M4, S_SUM and S_OUT; when the variable
// integration rate tapers it also passes S_M5 and S_DIV (a bit-serial divider pass),
// and in pass-through or deadband it goes from S_CHK straight to S_OUT. One request
// at a time; all products go through the shared multiplier.
// Reset sets the configuration registers to their defaults and clears the controller history.
module pid_controller_with_options_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [111:0]                s_tdata,  // measured, target, ext_derivative, step_time
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,  // drive
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pidc_pkg::IdxW-1:0]   cfg_index,
    input  logic [31:0]                 cfg_data
);
    import pidc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_M1, S_M2, S_M3, S_M4, S_M5, S_DIV, S_SUM, S_OUT
    } state_t;

    state_t state_reg;

    logic [GainW-1:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [GainW-1:0] output_max_reg, integ_limit_reg, dead_band_reg, full_rate_reg;
    logic [OptW-1:0]  option_reg;

    logic signed [DataW-1:0] integ_acc_reg, prev_error_reg;
    logic signed [DataW-1:0] target_reg, extd_reg, err_reg;
    logic [DtW-1:0]          dt_reg;
    logic signed [DataW-1:0] p_reg, d_reg, it_reg, drive_reg;
    logic signed [DataW-1:0] out_data_reg;
    logic                    it_neg_reg;
    logic                    out_valid_reg;
    logic                    out_load;

    logic signed [MulW-1:0]  mul_a, mul_b;
    logic signed [ProdW-1:0] prod;
    logic signed [DataW-1:0] qres;
    logic                    div_start, div_done;
    logic [DvdW-1:0]         div_q;

    logic signed [DataW:0]   meas_in, tgt_in;
    logic signed [DataW+1:0] err_in;
    logic [DataW-1:0]        err_mag;
    logic                    same_sign;
    logic                    taper_on, taper_skip;
    logic [MulW-1:0]         band_top;
    logic [MulW-1:0]         taper_c;
    logic [DataW:0]          it_mag;
    logic signed [DataW+1:0] trap_sum, ediff;
    logic signed [DataW+1:0] omax_s, lim_s;
    logic [DvdW-1:0]         q_lim;

    // combinational values of the final sum step
    logic signed [DataW+1:0] sum_ti, sum_pid, sum_y, sum_it, sum_ia;
    logic signed [DataW-1:0] ia_new;
    logic signed [DataW+1:0] clamp_p;

    pidc_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    pidc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod[DvdW-1:0]),
        .divisor  ((full_rate_reg == '0) ? GainW'(1) : full_rate_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign qres      = qsat(prod);
    assign meas_in   = {s_tdata[31], s_tdata[31:0]};
    assign tgt_in    = {s_tdata[63], s_tdata[63:32]};
    assign err_in    = {tgt_in[DataW], tgt_in} - {meas_in[DataW], meas_in};
    assign err_mag   = err_reg[DataW-1] ? DataW'(-err_reg) : DataW'(err_reg);
    assign same_sign = (err_reg > 0 && integ_acc_reg > 0) || (err_reg < 0 && integ_acc_reg < 0);
    assign band_top  = {2'b00, full_rate_reg} + TaperBand;
    assign taper_c   = band_top - {1'b0, err_mag};
    assign taper_on  = option_reg[OptVarRate] && same_sign
                       && ({1'b0, err_mag} > {2'b00, full_rate_reg});
    assign taper_skip = {1'b0, err_mag} > band_top;
    assign it_mag    = it_reg[DataW-1] ? (DataW+1)'(-{it_reg[DataW-1], it_reg})
                                       : {1'b0, it_reg};
    assign trap_sum  = (DataW+2)'(err_reg) + (DataW+2)'(prev_error_reg);
    assign ediff     = (DataW+2)'(err_reg) - (DataW+2)'(prev_error_reg);
    assign omax_s    = (DataW+2)'({1'b0, output_max_reg});
    assign lim_s     = (DataW+2)'({1'b0, integ_limit_reg});
    assign clamp_p   = (DataW+2)'(qres);
    assign q_lim     = DvdW'(33'h0_8000_0000) - (it_neg_reg ? DvdW'(0) : DvdW'(1));
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_CHK:
            begin
                mul_a = MulW'({1'b0, prop_gain_reg});
                mul_b = MulW'(err_reg);
            end
            S_M1:
            begin
                mul_a = MulW'({1'b0, integ_gain_reg});
                mul_b = option_reg[OptTrap] ? MulW'(trap_sum >>> 1) : MulW'(err_reg);
            end
            S_M2:
            begin
                mul_a = MulW'(qres);
                mul_b = MulW'({1'b0, dt_reg});
            end
            S_M3:
            begin
                mul_a = MulW'({1'b0, deriv_gain_reg});
                mul_b = option_reg[OptDMeas] ? MulW'(extd_reg) : MulW'(sat34(ediff));
            end
            S_M4:
            begin
                mul_a = MulW'(it_mag);
                mul_b = taper_c;
            end
            S_IDLE, S_M5, S_DIV, S_SUM, S_OUT:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign div_start = (state_reg == S_M5);

    // integral limiting, accumulator update and output clamp
    always_comb
    begin
        sum_it  = (DataW+2)'(it_reg);
        sum_ia  = (DataW+2)'(integ_acc_reg);
        sum_ti  = sum_ia + sum_it;
        sum_pid = (DataW+2)'(p_reg) + sum_ia + (DataW+2)'(d_reg);
        if (option_reg[OptILimit])
        begin
            if (((sum_pid > omax_s) || (sum_pid < -omax_s)) && same_sign)
                sum_it = '0;
            if (sum_ti > lim_s)
            begin
                sum_it = '0;
                sum_ia = lim_s;
            end
            if (sum_ti < -lim_s)
            begin
                sum_it = '0;
                sum_ia = -lim_s;
            end
        end
        ia_new = sat34(sum_ia + sum_it);
        sum_y  = (DataW+2)'(p_reg) + (DataW+2)'(ia_new) + (DataW+2)'(d_reg);
        if (sum_y > omax_s)
            sum_y = omax_s;
        if (sum_y < -omax_s)
            sum_y = -omax_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            output_max_reg  <= '1;
            integ_limit_reg <= '1;
            dead_band_reg   <= '0;
            option_reg      <= '0;
            full_rate_reg   <= GainW'(65536);
            integ_acc_reg   <= '0;
            prev_error_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (reg_index_t'(cfg_index))
                    REG_PROP_GAIN:   prop_gain_reg   <= cfg_data[GainW-1:0];
                    REG_INTEG_GAIN:  integ_gain_reg  <= cfg_data[GainW-1:0];
                    REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_data[GainW-1:0];
                    REG_OUTPUT_MAX:  output_max_reg  <= cfg_data[GainW-1:0];
                    REG_INTEG_LIMIT: integ_limit_reg <= cfg_data[GainW-1:0];
                    REG_DEAD_BAND:   dead_band_reg   <= cfg_data[GainW-1:0];
                    REG_OPTION_BITS: option_reg      <= cfg_data[OptW-1:0];
                    REG_FULL_RATE:   full_rate_reg   <= cfg_data[GainW-1:0];
                    default:         option_reg      <= option_reg;
                endcase
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                        state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (option_reg[OptPass])
                        state_reg <= S_OUT;
                    else if (err_mag <= {1'b0, dead_band_reg})
                    begin
                        integ_acc_reg <= '0;
                        state_reg     <= S_OUT;
                    end
                    else
                        state_reg <= S_M1;
                end
                S_M1: state_reg <= S_M2;
                S_M2: state_reg <= S_M3;
                S_M3: state_reg <= S_M4;
                S_M4:
                begin
                    if (taper_on && !taper_skip)
                        state_reg <= S_M5;
                    else
                        state_reg <= S_SUM;
                end
                S_M5: state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_done)
                        state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    integ_acc_reg  <= ia_new;
                    prev_error_reg <= err_reg;
                    state_reg      <= S_OUT;
                end
                S_OUT:
                begin
                    // hold until the output register is free
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                target_reg <= s_tdata[63:32];
                extd_reg   <= s_tdata[95:64];
                dt_reg     <= s_tdata[111:96];
                err_reg    <= sat34(err_in);
            end
            S_CHK:
            begin
                drive_reg <= option_reg[OptPass] ? target_reg : '0;
            end
            S_M1:
            begin
                if (clamp_p > omax_s)
                    p_reg <= DataW'(omax_s);
                else if (clamp_p < -omax_s)
                    p_reg <= DataW'(-omax_s);
                else
                    p_reg <= qres;
            end
            S_M3:
            begin
                it_reg     <= qres;
                it_neg_reg <= qres[DataW-1];
            end
            S_M4:
            begin
                d_reg <= qres;
                // drop the integral step beyond the taper region
                if (taper_on && taper_skip)
                    it_reg <= '0;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (div_q > q_lim)
                        it_reg <= it_neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    else
                        it_reg <= it_neg_reg ? DataW'(-div_q) : DataW'(div_q);
                end
            end
            S_SUM:
            begin
                drive_reg <= DataW'(sum_y);
            end
            S_OUT:
            begin
                if (out_load)
                    out_data_reg <= drive_reg;
            end
            S_M2, S_M5:
            begin
                drive_reg <= drive_reg;
            end
            default:
            begin
                drive_reg <= drive_reg;
            end
        endcase
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

endmodule
